// ===== src/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg
// Shared sizes, command codes and status codes for the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int CAPACITY = 32;                     // list slots, 2..64
  localparam int IDX_W    = $clog2(CAPACITY);       // slot index width
  localparam int CNT_W    = $clog2(CAPACITY + 1);   // holds 0..CAPACITY

  localparam int CMD_W    = 3;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 7;
  localparam int COUNT_W  = 7;

  localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd4;

  localparam logic signed [DATA_W-1:0] NO_VALUE = -32'sd1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

endpackage

// ===== src/positional_list_engine.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed 32-bit words, addressed by one-based position, with
// push front, insert, read, write and remove commands.
// ----------------------------------------------------------------------------
//
//  channel | handshake                 | payload
//  --------+---------------------------+-----------------------------------
//  command | in_valid_i / in_stall_o   | command_i, value_i, position_i
//  result  | out_valid_o / out_stall_i | read_value_o, status_o, count_o
//
// One command beat per cycle, sustained while the result side is not
// stalled. A beat is captured in the input register, then resolved in one
// pass against the slot array (parallel shift of every slot plus a single
// indexed read) into the result register, which presents the result.
// Reset clears the count and both valid flags; slot contents are left as
// they are and are never read beyond the count.
// A stalled result holds the input register, which in turn stalls commands.
// ----------------------------------------------------------------------------
module positional_list_engine
  import ple_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,

  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [CMD_W-1:0]         command_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic [POS_W-1:0]         position_i,

  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] read_value_o,
  output logic [1:0]               status_o,
  output logic [COUNT_W-1:0]       count_o
);

  // Input register
  logic                     in_valid_q;
  logic [CMD_W-1:0]         cmd_q;
  logic signed [DATA_W-1:0] value_q;
  logic [POS_W-1:0]         pos_q;

  // List state
  logic [DATA_W-1:0] slot_q [CAPACITY];
  logic [DATA_W-1:0] slot_d [CAPACITY];
  logic [DATA_W-1:0] slot_up [CAPACITY];   // neighbour below (for insert shift)
  logic [DATA_W-1:0] slot_dn [CAPACITY];   // neighbour above (for remove shift)
  logic [CNT_W-1:0]  count_q, count_d;

  // Result register
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] res_value_q, res_value_d;
  status_e                  res_status_q, res_status_d;
  logic [COUNT_W-1:0]       res_count_q;

  logic advance;     // input register moves into the result register
  logic take_in;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign take_in    = in_valid_i && !in_stall_o;

  // Fixed neighbour taps for the shifts
  for (genvar g = 0; g < CAPACITY; g++) begin : g_taps
    if (g == 0) begin : g_first
      assign slot_up[g] = slot_q[g];
    end else begin : g_rest
      assign slot_up[g] = slot_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign slot_dn[g] = slot_q[g];
    end else begin : g_inner
      assign slot_dn[g] = slot_q[g+1];
    end
  end

  // Command decode against the current state
  logic [COUNT_W-1:0] cnt_ext;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   ins_idx;
  logic               pos_ok, is_empty, is_full;
  logic               do_ins, do_wr, do_rm;

  always_comb begin
    cnt_ext  = COUNT_W'(count_q);
    idx      = IDX_W'(pos_q - POS_W'(1));
    is_empty = (count_q == '0);
    is_full  = (count_q == CNT_W'(CAPACITY));
    pos_ok   = (pos_q != '0) && (COUNT_W'(pos_q) <= cnt_ext);

    do_ins       = 1'b0;
    do_wr        = 1'b0;
    do_rm        = 1'b0;
    ins_idx      = '0;
    res_value_d  = NO_VALUE;
    res_status_d = ST_OK;

    case (cmd_q)
      CMD_PUSH: begin
        if (is_full) res_status_d = ST_FULL;
        else         do_ins       = 1'b1;
      end
      CMD_INSERT, CMD_READ, CMD_WRITE, CMD_REMOVE: begin
        if (is_empty) begin
          res_status_d = ST_EMPTY;
        end else if (!pos_ok) begin
          res_status_d = ST_BADPOS;
        end else if (cmd_q == CMD_INSERT) begin
          // position one is a push front; both share the same slot path
          if (is_full) begin
            res_status_d = ST_FULL;
          end else begin
            do_ins  = 1'b1;
            ins_idx = idx;
          end
        end else if (cmd_q == CMD_READ) begin
          res_value_d = slot_q[idx];
        end else if (cmd_q == CMD_WRITE) begin
          do_wr = 1'b1;
        end else begin
          res_value_d = slot_q[idx];
          do_rm       = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Next slot contents: every slot picks from itself, a neighbour or the value
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      slot_d[i] = slot_q[i];
      if (do_ins) begin
        if (IDX_W'(i) == ins_idx)     slot_d[i] = value_q;
        else if (IDX_W'(i) > ins_idx) slot_d[i] = slot_up[i];
      end else if (do_rm) begin
        if (IDX_W'(i) >= idx)         slot_d[i] = slot_dn[i];
      end else if (do_wr) begin
        if (IDX_W'(i) == idx)         slot_d[i] = value_q;
      end
    end
    count_d = count_q;
    if (do_ins)     count_d = count_q + CNT_W'(1);
    else if (do_rm) count_d = count_q - CNT_W'(1);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      if (take_in)       in_valid_q <= 1'b1;
      else if (advance)  in_valid_q <= 1'b0;
      if (advance)                         out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (advance) count_q <= count_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      cmd_q   <= command_i;
      value_q <= value_i;
      pos_q   <= position_i;
    end
    if (advance) begin
      slot_q       <= slot_d;
      res_value_q  <= res_value_d;
      res_status_q <= res_status_d;
      res_count_q  <= COUNT_W'(count_d);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = res_value_q;
  assign status_o     = res_status_q;
  assign count_o      = res_count_q;

  // Assertions
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("list count above capacity");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_status_q == ST_FULL) |-> res_count_q == COUNT_W'(CAPACITY))
    else $error("full status with list not full");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_status_q == ST_EMPTY) |-> res_count_q == '0)
    else $error("empty status with entries present");

  a_err_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_status_q != ST_OK) |-> res_value_q == NO_VALUE)
    else $error("error result carries a value");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> count_q == $past(count_q))
    else $error("count changed without a command");

endmodule

// ===== bench/ple_checker.sv =====
// ----------------------------------------------------------------------------
// ple_checker
// Watches both channels of the positional list engine. Every accepted
// command beat goes through a cycle-free model of the list, and the result it
// should give is queued. Every accepted result beat is compared field by
// field with the oldest queued result.
// ----------------------------------------------------------------------------
module ple_checker
  import ple_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,

  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic [CMD_W-1:0]         command_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic [POS_W-1:0]         position_i,

  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic signed [DATA_W-1:0] read_value_i,
  input  logic [1:0]               status_i,
  input  logic [COUNT_W-1:0]       count_i,

  output int                       fail_count_o,
  output int                       pending_o,
  output int                       list_count_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [DATA_W-1:0] read_value;
    status_e                  status;
    logic [COUNT_W-1:0]       count;
  } list_result_t;

  logic signed [DATA_W-1:0] slots [CAPACITY];
  int unsigned              stored;
  list_result_t             expected_q [$];
  int                       fails;

  assign fail_count_o = fails;
  assign list_count_o = stored;

  initial begin
    fails     = 0;
    stored    = 0;
    pending_o = 0;
  end

  // Open a gap at slot idx and drop the word into it.
  function automatic void insert_word(int unsigned idx, logic signed [DATA_W-1:0] word);
    for (int unsigned i = stored; i > idx; i--) slots[i] = slots[i-1];
    slots[idx] = word;
    stored++;
  endfunction

  function automatic status_e push_front(logic signed [DATA_W-1:0] word);
    if (stored >= CAPACITY) return ST_FULL;
    insert_word(0, word);
    return ST_OK;
  endfunction

  // Applies one command to the list model and gives the result it causes.
  function automatic list_result_t apply_command(logic [CMD_W-1:0]         cmd,
                                                 logic signed [DATA_W-1:0] word,
                                                 logic [POS_W-1:0]         pos);
    list_result_t r;
    logic         pos_ok;
    r.read_value = NO_VALUE;
    r.status     = ST_OK;
    pos_ok       = (pos >= 1) && (pos <= stored);
    case (cmd)
      CMD_PUSH: begin
        r.status = push_front(word);
      end
      CMD_INSERT, CMD_READ, CMD_WRITE, CMD_REMOVE: begin
        if (stored == 0) begin
          r.status = ST_EMPTY;
        end else if (!pos_ok) begin
          r.status = ST_BADPOS;
        end else if (cmd == CMD_INSERT) begin
          // position 1 is a plain push front
          if (pos == 1)                r.status = push_front(word);
          else if (stored >= CAPACITY) r.status = ST_FULL;
          else                         insert_word(pos - 1, word);
        end else if (cmd == CMD_READ) begin
          r.read_value = slots[pos-1];
        end else if (cmd == CMD_WRITE) begin
          slots[pos-1] = word;
        end else begin
          r.read_value = slots[pos-1];
          for (int unsigned i = pos - 1; i + 1 < stored; i++) slots[i] = slots[i+1];
          stored--;
        end
      end
      default: ;  // spare codes: no change, ok, no value
    endcase
    r.count = COUNT_W'(stored);
    return r;
  endfunction

  // Result first: a result can never belong to a command of the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t head;
    if (!rst_ni) begin
      stored = 0;
      expected_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected: value %0d status %0d count %0d",
                 read_value_i, status_i, count_i);
          fails++;
        end else begin
          head = expected_q.pop_front();
          if (read_value_i !== head.read_value) begin
            $error("read_value: expected %0d, got %0d", head.read_value, read_value_i);
            fails++;
          end
          if (status_i !== head.status) begin
            $error("status: expected %0d, got %0d", head.status, status_i);
            fails++;
          end
          if (count_i !== head.count) begin
            $error("count: expected %0d, got %0d", head.count, count_i);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_q.push_back(apply_command(command_i, value_i, position_i));
    end
    pending_o = expected_q.size();
  end

endmodule

// ===== bench/positional_list_engine_tb.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine_tb
// Drives command beats into the positional list engine and leaves all the
// checking to ple_checker. A short directed run covers the empty and
// bad-position corners and the spare codes; a random run then swings the
// list between empty and full under three idling regimes.
// ----------------------------------------------------------------------------
module positional_list_engine_tb
  import ple_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES = 10;
  localparam int IDLE_LIMIT   = 1000;  // cycles with no beat on either side
  localparam int HOLD_AT      = 480;   // command beats sent before the long hold
  localparam int HOLD_CYCLES  = 80;    // long receiver hold, well past the depth
  localparam int TAIL_CYCLES  = 6;     // pipeline is two deep; a little slack

  logic                     clk;
  logic                     rst_n      = 1'b0;
  logic                     in_valid   = 1'b0;
  logic                     in_stall;
  logic [CMD_W-1:0]         command    = CMD_PUSH;
  logic signed [DATA_W-1:0] value      = '0;
  logic [POS_W-1:0]         position   = '0;
  logic                     out_valid;
  logic                     out_stall  = 1'b0;
  logic signed [DATA_W-1:0] read_value;
  logic [1:0]               status;
  logic [COUNT_W-1:0]       count;

  int fails;
  int pending;
  int list_count;

  // idling odds in percent, changed per phase
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int beats_sent     = 0;
  int hold_left      = 0;
  bit hold_done      = 1'b0;
  int idle_cycles    = 0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  positional_list_engine dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .command_i    (command),
    .value_i      (value),
    .position_i   (position),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .read_value_o (read_value),
    .status_o     (status),
    .count_o      (count)
  );

  ple_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .command_i    (command),
    .value_i      (value),
    .position_i   (position),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .read_value_i (read_value),
    .status_i     (status),
    .count_i      (count),
    .fail_count_o (fails),
    .pending_o    (pending),
    .list_count_o (list_count)
  );

  // Receiver: random stalls, plus one long hold late in the run so the
  // result register and then the command register fill and push back.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (!hold_done && beats_sent >= HOLD_AT) begin
      out_stall = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      hold_done = 1'b1;
    end else begin
      out_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: only cycles in which neither channel moves a beat count.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Offer one command beat; called and returns at a falling edge. Valid
  // stays high from one beat to the next unless an idle cycle is drawn.
  task automatic send_beat(logic [CMD_W-1:0]         cmd,
                           logic signed [DATA_W-1:0] word,
                           logic [POS_W-1:0]         pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    command  = cmd;
    value    = word;
    position = pos;
    do @(posedge clk); while (in_stall);
    beats_sent++;
    @(negedge clk);
  endtask

  // Random beat. grow_list biases towards pushes and inserts, otherwise
  // towards removes; positions are mostly in range, with edge and wild ones.
  task automatic send_random(bit grow_list);
    int                       pick;
    int                       cnt;
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] word;
    logic [POS_W-1:0]         pos;
    cnt  = list_count;
    pick = $urandom_range(99);
    if (pick >= 95)
      cmd = CMD_W'($urandom_range(2**CMD_W - 1, CMD_REMOVE + 1));
    else if (grow_list)
      cmd = (pick < 35) ? CMD_PUSH  : (pick < 65) ? CMD_INSERT :
            (pick < 75) ? CMD_READ  : (pick < 85) ? CMD_WRITE  : CMD_REMOVE;
    else
      cmd = (pick < 10) ? CMD_PUSH  : (pick < 20) ? CMD_INSERT :
            (pick < 30) ? CMD_READ  : (pick < 40) ? CMD_WRITE  : CMD_REMOVE;
    pick = $urandom_range(99);
    if (cnt > 0 && pick < 85)  pos = POS_W'($urandom_range(cnt, 1));
    else if (pick < 90)        pos = '0;
    else if (pick < 95)        pos = POS_W'(cnt + 1);
    else                       pos = POS_W'($urandom_range(2**POS_W - 1));
    case ($urandom_range(19))
      0:       word = {1'b1, {(DATA_W-1){1'b0}}};
      1:       word = {1'b0, {(DATA_W-1){1'b1}}};
      2:       word = '0;
      3:       word = NO_VALUE;
      default: word = DATA_W'($urandom);
    endcase
    send_beat(cmd, word, pos);
  endtask

  task automatic random_phase(int beats, int idle_pct, int stall_pct);
    bit grow_list;
    grow_list      = 1'b1;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (beats) begin
      // linger a while at full and at empty so both corners get hammered
      if (list_count >= CAPACITY && $urandom_range(5) == 0) grow_list = 1'b0;
      if (list_count == 0 && $urandom_range(3) == 0)        grow_list = 1'b1;
      send_random(grow_list);
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // empty list: every positional command reports empty
    send_beat(CMD_READ,   32'sd7, 7'd1);
    send_beat(CMD_WRITE,  32'sd7, 7'd1);
    send_beat(CMD_REMOVE, 32'sd7, 7'd1);
    send_beat(CMD_INSERT, 32'sd7, 7'd1);
    // spare codes leave everything alone
    for (int c = CMD_REMOVE + 1; c < 2**CMD_W; c++)
      send_beat(CMD_W'(c), NO_VALUE, {POS_W{1'b1}});
    // build a short list, value extremes included
    send_beat(CMD_PUSH,   {1'b1, {(DATA_W-1){1'b0}}}, '0);
    send_beat(CMD_PUSH,   {1'b0, {(DATA_W-1){1'b1}}}, '0);
    send_beat(CMD_INSERT, 32'sd0, 7'd1);              // insert at 1 = push front
    send_beat(CMD_INSERT, NO_VALUE, 7'd3);            // before the last entry
    send_beat(CMD_INSERT, 32'sh5a5a5a5a, 7'd2);
    // bad positions: zero, one past the end, far out
    send_beat(CMD_READ,   32'sd0, 7'd0);
    send_beat(CMD_READ,   32'sd0, 7'd6);
    send_beat(CMD_READ,   32'sd0, 7'd64);
    send_beat(CMD_INSERT, 32'sd1, {POS_W{1'b1}});
    // overwrite the tail, read it back, then peel both ends
    send_beat(CMD_WRITE,  32'sh12345678, 7'd5);
    send_beat(CMD_READ,   32'sd0, 7'd5);
    send_beat(CMD_READ,   32'sd0, 7'd1);
    send_beat(CMD_REMOVE, 32'sd0, 7'd5);
    send_beat(CMD_REMOVE, 32'sd0, 7'd1);
    send_beat(CMD_REMOVE, 32'sd0, 7'd0);
    send_beat(CMD_WRITE,  32'sd9, 7'd0);

    // sender idles a little, receiver a lot; then the reverse; then flat out
    random_phase(200, 27, 56);
    random_phase(200, 56, 27);
    random_phase(150, 0, 0);

    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
